// ===== design/pcpf_pkg.sv =====
// shared types and constants of the path crossing point finder
`default_nettype none

package pcpf_pkg;

    localparam int CELL_W    = 20;
    localparam int OUT_IDX_W = 8;
    localparam int MATCH_W   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } t_state;

    typedef enum logic {
        ACT_LOAD_SECOND = 1'b0,
        ACT_QUERY_FIRST = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [CELL_W-1:0] cell_number;
        logic              final_cell;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [MATCH_W-1:0]   match_number;
        logic [OUT_IDX_W-1:0] first_path_index;
        logic [OUT_IDX_W-1:0] second_path_index;
        logic                 query_done;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/pcpf_if.sv =====
// valid/ready channels for input items and result items
`default_nettype none

interface pcpf_in_if;
    logic               valid;
    logic               ready;
    pcpf_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcpf_out_if;
    logic                valid;
    logic                ready;
    pcpf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pcpf_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module pcpf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/path_crossing_point_finder.sv =====
// top level of the path crossing point finder
`default_nettype none

// Load the second path first (action 0), one cell per item; each load item writes one
// entry of the cell store while it is not full. A first-path item (action 1) gives one
// result. An interior first-path cell against a complete second path of length L >= 3
// is compared with stored cells 1 .. L-2 in order through the single read port of the
// store, one comparison per cycle, stopping at the first equal cell; any other first-path
// item is reported without a search. The result sits in an output register; a new
// result waits only if the previous one has not been taken. Only the low CELL_BITS bits
// of a cell number are compared.
module path_crossing_point_finder #(
    parameter int MAX_PATH_CELLS = 256,
    parameter int CELL_BITS      = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pcpf_in_if.sink     i_in,
    pcpf_out_if.source  o_out
);

    import pcpf_pkg::*;

    localparam int IDX_W      = $clog2(MAX_PATH_CELLS);
    localparam int LEN_W      = $clog2(MAX_PATH_CELLS + 1);
    localparam int STORE_BITS = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATH_CELLS);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);
    localparam logic [IDX_W-1:0] POS_MAX = IDX_W'(MAX_PATH_CELLS - 1);

    t_state r_state, n_state;

    // second path bookkeeping
    logic [LEN_W-1:0] r_len;
    logic             r_complete;
    // first path bookkeeping
    logic [IDX_W-1:0]   r_pos;
    logic [MATCH_W-1:0] r_matches;

    // item under search
    logic [STORE_BITS-1:0] r_cell;
    logic                  r_last;
    logic [IDX_W-1:0]      r_q_pos;
    logic [LEN_W-1:0]      r_scan;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_where;

    logic      r_out_vld;
    t_out_item r_out;

    logic                  in_acc;
    logic                  is_load;
    logic                  do_search;
    logic [LEN_W-1:0]      len_base;
    logic                  wr_en;
    logic                  rd_en;
    logic                  match;
    logic                  scan_end;
    logic                  out_load;
    logic [STORE_BITS-1:0] rd_data;
    logic [IDX_W+OUT_IDX_W-1:0] pos_ext;
    logic [IDX_W+OUT_IDX_W-1:0] where_ext;

    pcpf_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (MAX_PATH_CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (len_base[IDX_W-1:0]),
        .i_wr_data (i_in.data.cell_number[STORE_BITS-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // control outputs of the sequencer
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        in_acc     = i_in.valid && i_in.ready;
        is_load    = (i_in.data.action == ACT_LOAD_SECOND);
        len_base   = r_complete ? '0 : r_len;
        wr_en      = in_acc && is_load && (len_base < MAX_LEN);
        do_search  = (r_pos != '0) && !i_in.data.final_cell && r_complete
                     && (r_len >= MIN_LEN);
        rd_en      = (r_state == ST_SCAN)
                     && (({1'b0, r_scan} + 1'b1) < {1'b0, r_len});
        match      = (r_state == ST_SCAN) && r_cmp_vld && (rd_data == r_cell);
        scan_end   = (r_state == ST_SCAN) && !rd_en && !r_cmp_vld;
        out_load   = (r_state == ST_REPORT) && (!r_out_vld || o_out.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !is_load) begin
                    n_state = do_search ? ST_SCAN : ST_REPORT;
                end
            end
            ST_SCAN: begin
                if (match || scan_end) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // path bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_complete <= 1'b0;
            r_pos      <= '0;
            r_matches  <= '0;
        end else begin
            if (in_acc && is_load) begin
                r_len      <= wr_en ? len_base + 1'b1 : len_base;
                r_complete <= i_in.data.final_cell;
            end
            if (out_load) begin
                if (r_last) begin
                    r_pos     <= '0;
                    r_matches <= '0;
                end else begin
                    if (r_pos != POS_MAX) begin
                        r_pos <= r_pos + 1'b1;
                    end
                    if (r_hit) begin
                        r_matches <= r_matches + 1'b1;
                    end
                end
            end
        end
    end

    // search of the stored interior cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (in_acc && !is_load) begin
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_vld <= rd_en && !match;
                if (match) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_load) begin
            r_cell  <= i_in.data.cell_number[STORE_BITS-1:0];
            r_last  <= i_in.data.final_cell;
            r_q_pos <= r_pos;
            r_scan  <= LEN_W'(1);
        end else if (rd_en) begin
            r_scan <= r_scan + 1'b1;
        end
        if (rd_en) begin
            r_cmp_idx <= r_scan[IDX_W-1:0];
        end
        if (match) begin
            r_where <= r_cmp_idx;
        end
    end

    // output register
    assign pos_ext   = {{OUT_IDX_W{1'b0}}, r_q_pos};
    assign where_ext = {{OUT_IDX_W{1'b0}}, r_where};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.found             <= r_hit;
            r_out.match_number      <= r_hit ? r_matches : '0;
            r_out.first_path_index  <= pos_ext[OUT_IDX_W-1:0];
            r_out.second_path_index <= r_hit ? where_ext[OUT_IDX_W-1:0] : '0;
            r_out.query_done        <= r_last;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan < r_len))
        else $error("scan index beyond second path length");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("store written while searching");

    a_hit_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_REPORT) && r_hit) |-> ((r_where != '0) && !r_last))
        else $error("match reported outside the interior");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_out)))
        else $error("pending result overwritten");

    a_report_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after a result");

endmodule

`default_nettype wire

// ===== sim/pcpf_crossing_checker.sv =====
// predicts and checks every result item of the path crossing point finder
`default_nettype none

module pcpf_crossing_checker
    import pcpf_pkg::*;
#(
    parameter int MAX_PATH_CELLS = 256,
    parameter int CELL_BITS      = 20
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pcpf_in_if        i_in_mon,
    pcpf_out_if       i_out_mon,
    output int        o_mismatches,
    output int        o_pending
);

    localparam logic [CELL_W-1:0] CELL_MASK = CELL_W'((64'd1 << CELL_BITS) - 64'd1);

    logic [CELL_W-1:0]  stored_cells [MAX_PATH_CELLS];
    int                 stored_len;
    bit                 stored_closed;
    int                 query_pos;
    logic [MATCH_W-1:0] match_cnt;
    t_out_item          crossings_due [$];
    int                 bad_count = 0;

    // one accepted item: update the path store and queue the result it causes
    function automatic void predict_crossing(t_in_item it);
        logic [CELL_W-1:0] cell_val;
        bit                hit;
        int                where;
        int                pos;
        int                c;
        t_out_item         res;
        cell_val = it.cell_number & CELL_MASK;
        if (it.action == ACT_LOAD_SECOND) begin
            // a load after a finished second path starts a new one
            if (stored_closed) begin
                stored_len    = 0;
                stored_closed = 1'b0;
            end
            if (stored_len < MAX_PATH_CELLS) begin
                stored_cells[stored_len] = cell_val;
                stored_len++;
            end
            if (it.final_cell)
                stored_closed = 1'b1;
        end else begin
            pos   = query_pos;
            hit   = 1'b0;
            where = 0;
            if (pos >= 1 && !it.final_cell && stored_closed && stored_len >= 3) begin
                for (c = 1; c + 1 < stored_len; c++) begin
                    if (!hit && stored_cells[c] == cell_val) begin
                        hit   = 1'b1;
                        where = c;
                    end
                end
            end
            res.found             = hit;
            res.match_number      = hit ? match_cnt : '0;
            res.first_path_index  = OUT_IDX_W'(pos);
            res.second_path_index = hit ? OUT_IDX_W'(where) : '0;
            res.query_done        = it.final_cell;
            crossings_due = {crossings_due, res};
            if (hit)
                match_cnt = match_cnt + 1'b1;
            if (it.final_cell) begin
                query_pos = 0;
                match_cnt = '0;
            end else if (pos + 1 < MAX_PATH_CELLS) begin
                query_pos = pos + 1;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item due;
        t_out_item got;
        if (!i_rst_n) begin
            stored_len    = 0;
            stored_closed = 1'b0;
            query_pos     = 0;
            match_cnt     = '0;
            crossings_due.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                predict_crossing(i_in_mon.data);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (crossings_due.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: result item with none expected: found=%0d match=%0d",
                                 $time, got.found, got.match_number);
                end else begin
                    due = crossings_due.pop_front();
                    if (got.found !== due.found || got.match_number !== due.match_number ||
                        got.first_path_index !== due.first_path_index ||
                        got.second_path_index !== due.second_path_index ||
                        got.query_done !== due.query_done) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("%0t: crossing mismatch, expected found=%0d match=%0d",
                                     $time, due.found, due.match_number);
                            $display("    first_idx=%0d second_idx=%0d done=%0d",
                                     due.first_path_index, due.second_path_index,
                                     due.query_done);
                            $display("    got found=%0d match=%0d first_idx=%0d",
                                     got.found, got.match_number, got.first_path_index);
                            $display("    second_idx=%0d done=%0d",
                                     got.second_path_index, got.query_done);
                        end
                    end
                end
            end
        end
        o_pending    <= crossings_due.size();
        o_mismatches <= bad_count;
    end

endmodule

`default_nettype wire

// ===== sim/path_crossing_point_finder_tb.sv =====
// stimulus and verdict for the path crossing point finder
`default_nettype none

module path_crossing_point_finder_tb;
    import pcpf_pkg::*;

    typedef logic [CELL_W-1:0] t_cell_q [$];

    localparam int MAX_CELLS    = 256;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_HOLD    = 600;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_taken = 1'b0;
    int   mismatch_total;
    int   pending_results;
    int   items_sent  = 0;
    int   burst_left  = 0;
    int   gap_max     = 4;
    bit   calm        = 1'b0;
    int   rx_hold_req = 0;

    pcpf_in_if  in_ch ();
    pcpf_out_if out_ch ();

    path_crossing_point_finder #(
        .MAX_PATH_CELLS (MAX_CELLS),
        .CELL_BITS      (CELL_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pcpf_crossing_checker #(
        .MAX_PATH_CELLS (MAX_CELLS),
        .CELL_BITS      (CELL_W)
    ) crossing_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatch_total),
        .o_pending    (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // acceptance seen at the rising edge, read by the sender at the next falling edge
    always @(posedge i_clk)
        in_taken <= in_ch.valid && in_ch.ready;

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result receiver: changing stall patterns, plus long hold-offs on request
    initial begin : receiver
        int mode;
        int left;
        int hold;
        int tick;
        bit rdy;
        mode = 0;
        left = 0;
        hold = 0;
        tick = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (rx_hold_req != 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                rdy = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: begin
                        rdy = 1'b1;
                    end
                    1: begin
                        rdy = 1'(($urandom_range(0, 1)));
                    end
                    2: begin
                        rdy = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        rdy = ((tick % 7) < 3);
                    end
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    function automatic logic [CELL_W-1:0] rand_cell();
        case ($urandom_range(0, 3))
            0: return CELL_W'($urandom_range(0, 15));
            1: return {CELL_W{1'b1}} - CELL_W'($urandom_range(0, 15));
            default: return CELL_W'($urandom());
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] pick_from(t_cell_q src);
        return src[$urandom_range(0, src.size() - 1)];
    endfunction

    // a handful of values so that repeats within a path are common
    function automatic t_cell_q make_pool();
        t_cell_q pool;
        repeat (6) pool = {pool, rand_cell()};
        return pool;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cell(t_action act, logic [CELL_W-1:0] cell_val, bit last);
        int gap;
        if (burst_left == 0) begin
            gap        = calm ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{action: act, cell_number: cell_val, final_cell: last};
        do @(negedge i_clk); while (!in_taken);
        items_sent++;
    endtask

    task automatic send_path(t_action act, t_cell_q cells);
        int i;
        for (i = 0; i < cells.size(); i++)
            send_cell(act, cells[i], i == cells.size() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    task automatic directed_items();
        t_cell_q path;
        // first path cells with nothing loaded yet
        send_cell(ACT_QUERY_FIRST, 20'hFFFFF, 1'b0);
        send_cell(ACT_QUERY_FIRST, 20'h00000, 1'b1);
        // interior holds a repeated cell: the earlier index must win
        path = '{20'hABCDE, 20'h00000, 20'hFFFFF, 20'h00000, 20'h55555};
        send_path(ACT_LOAD_SECOND, path);
        // endpoints of either path never match
        path = '{20'hFFFFF, 20'h00000, 20'hABCDE, 20'h55555, 20'hFFFFF, 20'h00000};
        send_path(ACT_QUERY_FIRST, path);
        send_cell(ACT_QUERY_FIRST, 20'h12345, 1'b1);
        // second path too short for any match
        path = '{20'h00001, 20'h00002};
        send_path(ACT_LOAD_SECOND, path);
        path = '{20'h00001, 20'h00001, 20'h00002};
        send_path(ACT_QUERY_FIRST, path);
        path = '{20'h00007, 20'h00009, 20'h00007};
        send_path(ACT_LOAD_SECOND, path);
        path = '{20'h00009, 20'h00009, 20'h00009, 20'h00009};
        send_path(ACT_QUERY_FIRST, path);
        // query while a new second path is half loaded
        send_cell(ACT_LOAD_SECOND, 20'h00003, 1'b0);
        send_cell(ACT_QUERY_FIRST, 20'h00003, 1'b1);
        send_cell(ACT_LOAD_SECOND, 20'h00004, 1'b0);
        send_cell(ACT_LOAD_SECOND, 20'h00005, 1'b1);
    endtask

    // well-formed: a second path, then a few first paths drawing on its cells
    task automatic crossing_round();
        t_cell_q pool;
        t_cell_q second;
        t_cell_q first;
        int      len;
        int      r;
        pool = make_pool();
        r    = $urandom_range(0, 99);
        len  = (r < 8) ? $urandom_range(1, 2) :
               (r < 92) ? $urandom_range(3, 24) : $urandom_range(25, 80);
        repeat (len) second = {second, ($urandom_range(0, 1) ? pick_from(pool) : rand_cell())};
        send_path(ACT_LOAD_SECOND, second);
        repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 30);
            first.delete();
            repeat (len) begin
                r = $urandom_range(0, 9);
                first = {first, ((r < 6) ? pick_from(second) :
                                 (r < 8) ? pick_from(pool) : rand_cell())};
            end
            send_path(ACT_QUERY_FIRST, first);
        end
    endtask

    // loose items: loads and queries interleaved, paths cut short
    task automatic scramble(bit wild);
        t_cell_q pool;
        bit      load;
        bit      last;
        pool = make_pool();
        repeat ($urandom_range(5, 30)) begin
            load = wild ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
            last = wild ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
            send_cell(load ? ACT_LOAD_SECOND : ACT_QUERY_FIRST,
                      $urandom_range(0, 1) ? pick_from(pool) : rand_cell(), last);
        end
    endtask

    // second path at or beyond the store size, matches near its far end
    task automatic long_second(int len);
        t_cell_q second;
        t_cell_q first;
        int      kept;
        int      r;
        repeat (len) second = {second, CELL_W'($urandom())};
        send_path(ACT_LOAD_SECOND, second);
        kept = (len < MAX_CELLS) ? len : MAX_CELLS;
        repeat (2) begin
            first.delete();
            repeat (6) begin
                r = $urandom_range(0, 3);
                first = {first, ((r < 2) ? second[$urandom_range(kept - 6, kept - 1)] :
                                 (r == 2) ? second[$urandom_range(0, 1)] : rand_cell())};
            end
            send_path(ACT_QUERY_FIRST, first);
        end
    endtask

    // first path longer than the store: position saturates, match count wraps
    task automatic match_overflow();
        t_cell_q second;
        t_cell_q first;
        logic [CELL_W-1:0] mid;
        mid    = rand_cell();
        second = '{rand_cell(), mid, rand_cell()};
        send_path(ACT_LOAD_SECOND, second);
        repeat (300) first = {first, mid};
        send_path(ACT_QUERY_FIRST, first);
    endtask

    // receiver holds off while queries keep coming, so the input backs up
    task automatic backed_up();
        t_cell_q second;
        t_cell_q first;
        calm = 1'b1;
        repeat (8) second = {second, rand_cell()};
        send_path(ACT_LOAD_SECOND, second);
        rx_hold_req = LONG_HOLD;
        repeat (24) first = {first, ($urandom_range(0, 3) ? pick_from(second) : rand_cell())};
        send_path(ACT_QUERY_FIRST, first);
        wait_drained();
    endtask

    initial begin : stimulus
        int start;
        int round;
        int r;
        int waited;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_items();
        wait_drained();

        start = items_sent;
        round = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            round++;
            calm    = ($urandom_range(0, 4) == 0);
            gap_max = $urandom_range(1, 12);
            if (round == 3 || round == 18) begin
                backed_up();
            end else if (round == 6) begin
                long_second(260);
            end else if (round == 24) begin
                long_second(MAX_CELLS);
            end else if (round == 11) begin
                match_overflow();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    crossing_round();
                else
                    scramble(r < 86);
            end
            // now and then the sender waits for every result to come back
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results != 0 && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (MAX_CELLS + 50) @(negedge i_clk);
        if (mismatch_total == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
